>>> design/hdfm_pkg.sv
`default_nettype none
package hdfm_pkg;

	typedef struct packed {
		logic [7:0]  hdr;
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        fin;
	} act_t;

	typedef struct packed {
		logic [7:0]  rid;
		logic [31:0] boff;
		logic [31:0] bsize;
		logic [31:0] lmin;
		logic [31:0] lmax;
		logic        sgn;
		logic [15:0] upage;
		logic [15:0] usage;
	} rec_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	localparam logic [3:0] G_USAGE_PAGE = 4'd0;
	localparam logic [3:0] G_LOGICAL_MIN = 4'd1;
	localparam logic [3:0] G_LOGICAL_MAX = 4'd2;
	localparam logic [3:0] G_REPORT_SIZE = 4'd7;
	localparam logic [3:0] G_REPORT_ID = 4'd8;
	localparam logic [3:0] G_REPORT_COUNT = 4'd9;
	localparam logic [3:0] G_PUSH = 4'd10;
	localparam logic [3:0] G_POP = 4'd11;

	localparam logic [3:0] L_USAGE = 4'd0;
	localparam logic [3:0] L_USAGE_MIN = 4'd1;
	localparam logic [3:0] L_USAGE_MAX = 4'd2;

	localparam logic [3:0] M_INPUT = 4'd8;
	localparam logic [3:0] M_OUTPUT = 4'd9;
	localparam logic [3:0] M_COLLECTION = 4'd10;
	localparam logic [3:0] M_FEATURE = 4'd11;
	localparam logic [3:0] M_END_COLLECTION = 4'd12;

	localparam logic [1:0] SIZE_CODE_4 = 2'd3;

	localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
	localparam logic [15:0] PAGE_SIM = 16'h0002;
	localparam logic [15:0] PAGE_BUTTON = 16'h0009;
	localparam logic [15:0] U_X = 16'h0030;
	localparam logic [15:0] U_Y = 16'h0031;
	localparam logic [15:0] U_SLIDER = 16'h0036;
	localparam logic [15:0] U_HAT = 16'h0039;
	localparam logic [15:0] U_RUDDER = 16'h00BA;
	localparam logic [15:0] U_THROTTLE = 16'h00BB;
	localparam logic [15:0] U_TOE_BRAKE = 16'h00BF;

	localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
	localparam logic [1:0] ROLE_STICK = 2'd1;
	localparam logic [1:0] ROLE_THROTTLE = 2'd2;
	localparam logic [1:0] ROLE_PEDALS = 2'd3;

	localparam logic KIND_FIELD = 1'b0;
	localparam logic KIND_ROLE = 1'b1;

endpackage
`default_nettype wire

>>> design/hdfm_front.sv
`default_nettype none
module hdfm_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       desc_byte,
	input  wire logic             final_byte,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             q_full,
	output logic                  push,
	output hdfm_pkg::act_t        push_act
);

	logic [2:0]  phase_q;
	logic [7:0]  hdr_q;
	logic [31:0] acc_q;
	logic        take;
	logic        fire;
	logic [2:0]  hdr_nb;
	logic [2:0]  new_nb;
	logic [2:0]  diff;
	logic [2:0]  phase_dec;
	logic [31:0] acc_new;

	function automatic logic [2:0] nb_of(input logic [1:0] code);
		return (code == hdfm_pkg::SIZE_CODE_4) ? 3'd4 : {1'b0, code};
	endfunction

	assign in_stall = q_full;
	assign take = in_valid && !q_full;
	assign hdr_nb = nb_of(hdr_q[1:0]);
	assign new_nb = nb_of(desc_byte[1:0]);
	assign diff = hdr_nb - phase_q;
	assign phase_dec = phase_q - 3'd1;
	assign acc_new = acc_q | ({24'd0, desc_byte} << {diff[1:0], 3'b000});

	always_comb begin
		fire = 1'b0;
		push_act.hdr = desc_byte;
		push_act.data = 32'd0;
		push_act.nbytes = new_nb;
		push_act.fin = final_byte;
		if (phase_q == 3'd0) begin
			fire = (new_nb == 3'd0) || final_byte;
		end else begin
			push_act.hdr = hdr_q;
			push_act.nbytes = hdr_nb;
			if (phase_dec == 3'd0) begin
				fire = 1'b1;
				push_act.data = acc_new;
			end else begin
				fire = final_byte;
			end
		end
	end

	assign push = take && fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 3'd0;
		end else if (take) begin
			if (final_byte) begin
				phase_q <= 3'd0;
			end else if (phase_q == 3'd0) begin
				phase_q <= new_nb;
			end else begin
				phase_q <= phase_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == 3'd0) begin
				hdr_q <= desc_byte;
				acc_q <= 32'd0;
			end else begin
				acc_q <= acc_new;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/hdfm_queue.sv
`default_nettype none
module hdfm_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  hdfm_pkg::act_t        push_act,
	input  wire logic             pop,
	output hdfm_pkg::act_t        head,
	output logic                  empty,
	output logic                  full
);

	hdfm_pkg::act_t                  buf_q [hdfm_pkg::QDEPTH];
	logic [hdfm_pkg::QPTR_W-1:0]     wr_q;
	logic [hdfm_pkg::QPTR_W-1:0]     rd_q;
	logic [hdfm_pkg::QCNT_W-1:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == hdfm_pkg::QCNT_W'(hdfm_pkg::QDEPTH));
	assign head = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_act;
		end
	end

endmodule
`default_nettype wire

>>> design/hdfm_back.sv
`default_nettype none
module hdfm_back #(
	parameter int MAX_USAGES_HELD = 64,
	parameter int MAX_FIELDS = 63,
	parameter int STACK_DEPTH = 4,
	parameter int REPORT_ID_COUNT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             act_valid,
	input  hdfm_pkg::act_t        act_in,
	output logic                  pop,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic                  result_kind,
	output logic [7:0]            field_report_id,
	output logic [31:0]           field_bit_offset,
	output logic [31:0]           field_bit_size,
	output logic signed [31:0]    field_logical_min,
	output logic signed [31:0]    field_logical_max,
	output logic                  field_signed,
	output logic [15:0]           field_usage_page,
	output logic [15:0]           field_usage,
	output logic [1:0]            device_role,
	output logic                  last_result
);

	localparam int UCNT_W = $clog2(MAX_USAGES_HELD + 1);
	localparam int UIDX_W = (MAX_USAGES_HELD > 1) ? $clog2(MAX_USAGES_HELD) : 1;
	localparam int MF_W = $clog2(MAX_FIELDS + 1);
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SLOT_W = (REPORT_ID_COUNT > 1) ? $clog2(REPORT_ID_COUNT) : 1;
	localparam int RECIP = (65536 + REPORT_ID_COUNT - 1) / REPORT_ID_COUNT;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LD = 3'd1;
	localparam logic [2:0] S_URD = 3'd2;
	localparam logic [2:0] S_EV = 3'd3;
	localparam logic [2:0] S_MUL = 3'd4;
	localparam logic [2:0] S_WR = 3'd5;
	localparam logic [2:0] S_FLUSH = 3'd6;
	localparam logic [2:0] S_ROLE = 3'd7;

	logic [2:0]          state_q;
	logic [15:0]         gpage_q;
	logic [31:0]         glmin_q;
	logic [31:0]         glmax_q;
	logic [31:0]         gsize_q;
	logic [31:0]         gcount_q;
	logic [7:0]          gid_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [15:0]         s_page_q [STACK_DEPTH];
	logic [31:0]         s_lmin_q [STACK_DEPTH];
	logic [31:0]         s_lmax_q [STACK_DEPTH];
	logic [31:0]         s_size_q [STACK_DEPTH];
	logic [31:0]         s_count_q [STACK_DEPTH];
	logic [7:0]          s_id_q [STACK_DEPTH];
	logic [UCNT_W-1:0]   ucnt_q;
	logic [15:0]         umin_q;
	logic [15:0]         umax_q;
	logic [15:0]         ul_mem [MAX_USAGES_HELD];
	logic [15:0]         ul_rd_q;
	logic [REPORT_ID_COUNT-1:0] vld_q;
	logic [31:0]         off_mem [REPORT_ID_COUNT];
	logic [31:0]         off_rd_q;
	logic                vld_rd_q;
	logic [31:0]         off_q;
	logic [31:0]         i_q;
	logic [UCNT_W-1:0]   idx_q;
	logic [15:0]         seq_q;
	logic [31:0]         prod_q;
	logic                const_q;
	logic                fin_q;
	logic [MF_W-1:0]     mapped_q;
	logic [MF_W-1:0]     stick_q;
	logic [MF_W-1:0]     throttle_q;
	logic [MF_W-1:0]     pedal_q;
	logic [MF_W-1:0]     hat_q;
	logic [MF_W-1:0]     button_q;
	hdfm_pkg::rec_t      held_q;
	logic                held_v_q;
	logic                ov_q;
	logic                okind_q;
	hdfm_pkg::rec_t      orec_q;
	logic [1:0]          orole_q;
	logic                olast_q;

	logic [1:0]          typ;
	logic [3:0]          tag;
	logic [31:0]         d;
	logic                idle_act;
	logic                do_push;
	logic                do_pop;
	logic                do_uwr;
	logic [DEPTH_W-1:0]  depth_m1;
	logic [SIDX_W-1:0]   pop_idx;
	logic [SIDX_W-1:0]   push_idx;
	logic [24:0]         qprod;
	logic [15:0]         qm;
	logic [15:0]         rem;
	logic [SLOT_W-1:0]   slot_c;
	logic                listmode;
	logic [15:0]         usage;
	logic                stable;
	logic                m;
	logic                emit;
	logic [MF_W-1:0]     mapped_nx;
	logic                brk;
	logic                last_ent;
	logic                ofree;
	logic                ev_go;
	logic                ld_held;
	logic                ld_role;
	logic [31:0]         mulres;
	logic [1:0]          role;
	hdfm_pkg::rec_t      rec;

	function automatic logic [31:0] widen(input logic [31:0] v, input logic [2:0] nb);
		if (nb == 3'd1) begin
			return {{24{v[7]}}, v[7:0]};
		end
		if (nb == 3'd2) begin
			return {{16{v[15]}}, v[15:0]};
		end
		return v;
	endfunction

	function automatic logic is_mapped(input logic [15:0] pg, input logic [15:0] u);
		if (pg == hdfm_pkg::PAGE_DESKTOP) begin
			return (u >= hdfm_pkg::U_X) && (u <= hdfm_pkg::U_HAT);
		end
		if (pg == hdfm_pkg::PAGE_SIM) begin
			return (u == hdfm_pkg::U_RUDDER) || (u == hdfm_pkg::U_THROTTLE) ||
				(u == hdfm_pkg::U_TOE_BRAKE);
		end
		return pg == hdfm_pkg::PAGE_BUTTON;
	endfunction

	assign typ = act_in.hdr[3:2];
	assign tag = act_in.hdr[7:4];
	assign d = act_in.data;
	assign idle_act = (state_q == S_IDLE) && act_valid;
	assign pop = idle_act;
	assign do_push = idle_act && typ == hdfm_pkg::TYPE_GLOBAL && tag == hdfm_pkg::G_PUSH &&
		depth_q < DEPTH_W'(STACK_DEPTH);
	assign do_pop = idle_act && typ == hdfm_pkg::TYPE_GLOBAL && tag == hdfm_pkg::G_POP &&
		depth_q != '0;
	assign do_uwr = idle_act && typ == hdfm_pkg::TYPE_LOCAL && tag == hdfm_pkg::L_USAGE &&
		ucnt_q < UCNT_W'(MAX_USAGES_HELD);
	assign depth_m1 = depth_q - 1'b1;
	assign pop_idx = depth_m1[SIDX_W-1:0];
	assign push_idx = depth_q[SIDX_W-1:0];

	// report id modulo table size by reciprocal
	assign qprod = {17'd0, gid_q} * 25'(RECIP);
	assign qm = 16'(qprod[24:16]) * 16'(REPORT_ID_COUNT);
	always_comb begin
		rem = {8'd0, gid_q} - qm;
		if (rem >= 16'(REPORT_ID_COUNT)) begin
			rem = rem - 16'(REPORT_ID_COUNT);
		end
	end
	assign slot_c = rem[SLOT_W-1:0];

	// usage choice for the current entry
	assign listmode = (ucnt_q != '0);
	always_comb begin
		usage = 16'd0;
		stable = 1'b1;
		if (listmode) begin
			usage = ul_rd_q;
			stable = !(({1'b0, idx_q} + 1'b1) < {1'b0, ucnt_q});
		end else if (umax_q != 16'd0) begin
			usage = seq_q;
			stable = !(seq_q < umax_q);
		end
	end

	assign m = is_mapped(gpage_q, usage);
	assign emit = m && (mapped_q < MF_W'(MAX_FIELDS));
	assign mapped_nx = mapped_q + MF_W'(emit);
	assign brk = stable && (!m || mapped_nx >= MF_W'(MAX_FIELDS));
	assign last_ent = brk || ((i_q + 32'd1) == gcount_q);
	assign ofree = !ov_q || !out_stall;
	assign ev_go = !(emit && held_v_q) || ofree;
	assign ld_held = (state_q == S_EV && ev_go && emit && held_v_q) ||
		(state_q == S_FLUSH && held_v_q && ofree);
	assign ld_role = (state_q == S_ROLE) && ofree;
	assign mulres = gsize_q * (gcount_q - i_q);

	always_comb begin
		rec.rid = gid_q;
		rec.boff = off_q;
		rec.bsize = gsize_q;
		rec.lmin = glmin_q;
		rec.lmax = glmax_q;
		rec.sgn = glmin_q[31];
		rec.upage = gpage_q;
		rec.usage = usage;
	end

	always_comb begin
		if (pedal_q != '0 && stick_q == '0) begin
			role = hdfm_pkg::ROLE_PEDALS;
		end else if (throttle_q != '0 && stick_q == '0 && hat_q == '0) begin
			role = hdfm_pkg::ROLE_THROTTLE;
		end else if (stick_q != '0 || button_q != '0) begin
			role = hdfm_pkg::ROLE_STICK;
		end else begin
			role = hdfm_pkg::ROLE_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gpage_q <= '0;
			glmin_q <= '0;
			glmax_q <= '0;
			gsize_q <= '0;
			gcount_q <= '0;
			gid_q <= '0;
			depth_q <= '0;
			ucnt_q <= '0;
			umin_q <= '0;
			umax_q <= '0;
			vld_q <= '0;
			mapped_q <= '0;
			stick_q <= '0;
			throttle_q <= '0;
			pedal_q <= '0;
			hat_q <= '0;
			button_q <= '0;
			held_v_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ld_held || ld_role) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (act_valid) begin
						case (typ)
							hdfm_pkg::TYPE_GLOBAL: begin
								case (tag)
									hdfm_pkg::G_USAGE_PAGE: gpage_q <= d[15:0];
									hdfm_pkg::G_LOGICAL_MIN: glmin_q <= widen(d, act_in.nbytes);
									hdfm_pkg::G_LOGICAL_MAX: glmax_q <= widen(d, act_in.nbytes);
									hdfm_pkg::G_REPORT_SIZE: gsize_q <= d;
									hdfm_pkg::G_REPORT_ID: gid_q <= d[7:0];
									hdfm_pkg::G_REPORT_COUNT: gcount_q <= d;
									hdfm_pkg::G_PUSH: begin
										if (do_push) begin
											depth_q <= depth_q + 1'b1;
										end
									end
									hdfm_pkg::G_POP: begin
										if (do_pop) begin
											depth_q <= depth_m1;
											gpage_q <= s_page_q[pop_idx];
											glmin_q <= s_lmin_q[pop_idx];
											glmax_q <= s_lmax_q[pop_idx];
											gsize_q <= s_size_q[pop_idx];
											gcount_q <= s_count_q[pop_idx];
											gid_q <= s_id_q[pop_idx];
										end
									end
									default: ;
								endcase
							end
							hdfm_pkg::TYPE_LOCAL: begin
								case (tag)
									hdfm_pkg::L_USAGE: begin
										if (do_uwr) begin
											ucnt_q <= ucnt_q + 1'b1;
										end
									end
									hdfm_pkg::L_USAGE_MIN: umin_q <= d[15:0];
									hdfm_pkg::L_USAGE_MAX: umax_q <= d[15:0];
									default: ;
								endcase
							end
							hdfm_pkg::TYPE_MAIN: begin
								case (tag)
									hdfm_pkg::M_OUTPUT, hdfm_pkg::M_COLLECTION,
									hdfm_pkg::M_FEATURE, hdfm_pkg::M_END_COLLECTION: begin
										ucnt_q <= '0;
										umin_q <= '0;
										umax_q <= '0;
									end
									default: ;
								endcase
							end
							default: ;
						endcase
						if (typ == hdfm_pkg::TYPE_MAIN && tag == hdfm_pkg::M_INPUT) begin
							state_q <= S_LD;
						end else if (act_in.fin) begin
							state_q <= S_ROLE;
						end
					end
				end
				S_LD: begin
					if (const_q || gcount_q == 32'd0) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_URD;
					end
				end
				S_URD: state_q <= S_EV;
				S_EV: begin
					if (ev_go) begin
						if (emit) begin
							held_v_q <= 1'b1;
							mapped_q <= mapped_nx;
							if (gpage_q == hdfm_pkg::PAGE_DESKTOP &&
								(usage == hdfm_pkg::U_X || usage == hdfm_pkg::U_Y)) begin
								stick_q <= stick_q + 1'b1;
							end
							if ((gpage_q == hdfm_pkg::PAGE_SIM && usage == hdfm_pkg::U_THROTTLE) ||
								(gpage_q == hdfm_pkg::PAGE_DESKTOP &&
								usage == hdfm_pkg::U_SLIDER)) begin
								throttle_q <= throttle_q + 1'b1;
							end
							if (gpage_q == hdfm_pkg::PAGE_SIM && (usage == hdfm_pkg::U_RUDDER ||
								usage == hdfm_pkg::U_TOE_BRAKE)) begin
								pedal_q <= pedal_q + 1'b1;
							end
							if (gpage_q == hdfm_pkg::PAGE_BUTTON) begin
								button_q <= button_q + 1'b1;
							end
							if (gpage_q == hdfm_pkg::PAGE_DESKTOP && usage == hdfm_pkg::U_HAT) begin
								hat_q <= hat_q + 1'b1;
							end
						end
						state_q <= last_ent ? S_MUL : S_URD;
					end
				end
				S_MUL: state_q <= S_WR;
				S_WR: begin
					vld_q[slot_c] <= 1'b1;
					ucnt_q <= '0;
					umin_q <= '0;
					umax_q <= '0;
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!held_v_q || ofree) begin
						held_v_q <= 1'b0;
						state_q <= fin_q ? S_ROLE : S_IDLE;
					end
				end
				S_ROLE: begin
					if (ofree) begin
						gpage_q <= '0;
						glmin_q <= '0;
						glmax_q <= '0;
						gsize_q <= '0;
						gcount_q <= '0;
						gid_q <= '0;
						depth_q <= '0;
						ucnt_q <= '0;
						umin_q <= '0;
						umax_q <= '0;
						vld_q <= '0;
						mapped_q <= '0;
						stick_q <= '0;
						throttle_q <= '0;
						pedal_q <= '0;
						hat_q <= '0;
						button_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ul_rd_q <= ul_mem[idx_q[UIDX_W-1:0]];
		off_rd_q <= off_mem[slot_c];
		vld_rd_q <= vld_q[slot_c];
		if (do_uwr) begin
			ul_mem[ucnt_q[UIDX_W-1:0]] <= d[15:0];
		end
		if (do_push) begin
			s_page_q[push_idx] <= gpage_q;
			s_lmin_q[push_idx] <= glmin_q;
			s_lmax_q[push_idx] <= glmax_q;
			s_size_q[push_idx] <= gsize_q;
			s_count_q[push_idx] <= gcount_q;
			s_id_q[push_idx] <= gid_q;
		end
		if (idle_act) begin
			const_q <= d[0];
			fin_q <= act_in.fin;
		end
		if (state_q == S_LD) begin
			off_q <= vld_rd_q ? off_rd_q : 32'd0;
			i_q <= 32'd0;
			idx_q <= '0;
			seq_q <= umin_q;
		end
		if (state_q == S_EV && ev_go) begin
			if (emit) begin
				held_q <= rec;
			end
			off_q <= off_q + gsize_q;
			i_q <= i_q + 32'd1;
			if (!stable) begin
				if (listmode) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					seq_q <= seq_q + 16'd1;
				end
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= mulres;
		end
		if (state_q == S_WR) begin
			off_mem[slot_c] <= off_q + prod_q;
		end
		if (ld_held) begin
			okind_q <= hdfm_pkg::KIND_FIELD;
			orec_q <= held_q;
			orole_q <= hdfm_pkg::ROLE_UNKNOWN;
			olast_q <= (state_q == S_FLUSH) && !fin_q;
		end else if (ld_role) begin
			okind_q <= hdfm_pkg::KIND_ROLE;
			orec_q <= '0;
			orole_q <= role;
			olast_q <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign result_kind = okind_q;
	assign field_report_id = orec_q.rid;
	assign field_bit_offset = orec_q.boff;
	assign field_bit_size = orec_q.bsize;
	assign field_logical_min = $signed(orec_q.lmin);
	assign field_logical_max = $signed(orec_q.lmax);
	assign field_signed = orec_q.sgn;
	assign field_usage_page = orec_q.upage;
	assign field_usage = orec_q.usage;
	assign device_role = orole_q;
	assign last_result = olast_q;

endmodule
`default_nettype wire

>>> design/hid_descriptor_field_mapper.sv
`default_nettype none
// channel  valid      stall      payload
// in       in_valid   in_stall   desc_byte, final_byte
// out      out_valid  out_stall  result_kind, field_*, device_role, last_result
//
// front takes one byte per cycle unless in_stall, into a two-entry item queue
// global, local and non-input main items are handled in the back end's idle state
// an input item runs load, a usage read and evaluate per report entry, multiply,
// write and flush; the walk stops early once the usage is fixed and no further
// record can follow; the final byte adds a role beat; out_stall holds the back end
// and in_stall rises only when the item queue is full; no clearing pass after reset
module hid_descriptor_field_mapper #(
	parameter int MAX_USAGES_HELD = 64,
	parameter int MAX_FIELDS = 63,
	parameter int STACK_DEPTH = 4,
	parameter int REPORT_ID_COUNT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       desc_byte,
	input  wire logic             final_byte,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  result_kind,
	output logic [7:0]            field_report_id,
	output logic [31:0]           field_bit_offset,
	output logic [31:0]           field_bit_size,
	output logic signed [31:0]    field_logical_min,
	output logic signed [31:0]    field_logical_max,
	output logic                  field_signed,
	output logic [15:0]           field_usage_page,
	output logic [15:0]           field_usage,
	output logic [1:0]            device_role,
	output logic                  last_result
);

	logic                q_full;
	logic                q_empty;
	logic                q_push;
	logic                q_pop;
	hdfm_pkg::act_t      q_in;
	hdfm_pkg::act_t      q_head;

	hdfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_byte  (desc_byte),
		.final_byte (final_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (q_push),
		.push_act   (q_in)
	);

	hdfm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_act (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	hdfm_back #(
		.MAX_USAGES_HELD (MAX_USAGES_HELD),
		.MAX_FIELDS      (MAX_FIELDS),
		.STACK_DEPTH     (STACK_DEPTH),
		.REPORT_ID_COUNT (REPORT_ID_COUNT)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.act_valid         (!q_empty),
		.act_in            (q_head),
		.pop               (q_pop),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.result_kind       (result_kind),
		.field_report_id   (field_report_id),
		.field_bit_offset  (field_bit_offset),
		.field_bit_size    (field_bit_size),
		.field_logical_min (field_logical_min),
		.field_logical_max (field_logical_max),
		.field_signed      (field_signed),
		.field_usage_page  (field_usage_page),
		.field_usage       (field_usage),
		.device_role       (device_role),
		.last_result       (last_result)
	);

`ifndef ASSERT_OFF
	a_role_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == hdfm_pkg::KIND_ROLE) |-> last_result)
		else $error("role beat without last mark");
	a_field_no_role: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == hdfm_pkg::KIND_FIELD) |->
		device_role == hdfm_pkg::ROLE_UNKNOWN)
		else $error("field beat carries a role");
	a_queue_safe: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full) && !(q_pop && q_empty))
		else $error("item queue overrun");
`endif

endmodule
`default_nettype wire
